// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Function codes of an input word
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0]  CH_NEWLINE  = 8'd10;
  localparam logic [7:0]  CH_TAB      = 8'd9;
  localparam logic [7:0]  CH_SPACE    = 8'd32;
  localparam logic [15:0] BLANK_CELL  = 16'h0720;
  localparam logic [7:0]  ATTR_RESET  = 8'h07;
  // Tab stops every 4 columns: column mod 4 is its two low bits
  localparam logic [1:0]  TAB_ALIGNED = 2'd0;

  // Register index decoded from paddr[2]
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] read_addr;
  } tcw_item_t;

  typedef struct packed {
    logic [10:0] cell_addr;
    logic [15:0] cell_value;
    logic        cell_written;
    logic        scrolled;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        last;
  } tcw_result_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_FINISH,
    ST_PUT
  } tcw_state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_BLANK,
    MEM_COPY,
    MEM_FILL,
    MEM_PUT,
    MEM_READ
  } tcw_mem_op_t;

  typedef enum logic [1:0] {
    EMIT_OFF,
    EMIT_BARE,
    EMIT_PUT,
    EMIT_READ
  } tcw_emit_t;

  typedef struct packed {
    logic        latch_item;
    logic        sweep_zero;
    logic        sweep_step;
    tcw_mem_op_t mem_op;
    logic        cur_home;
    logic        cur_newline;
    logic        cur_step;
    logic        mark_scroll;
    tcw_emit_t   emit;
    logic        emit_last;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_newline;
    logic       wrap_pending;
    logic       last_row;
    logic       copy_end;
    logic       sweep_end;
    logic       put_last;
  } tcw_status_t;

endpackage

// ===== src/tcw_ctrl.sv =====
// Sequencing state machine of the text console writer.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tcw_pkg::tcw_status_t sts,
  output tcw_pkg::tcw_cmd_t  cmd,
  output logic               busy
);
  import tcw_pkg::*;

  tcw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd.latch_item  = 1'b0;
    cmd.sweep_zero  = 1'b0;
    cmd.sweep_step  = 1'b0;
    cmd.mem_op      = MEM_NONE;
    cmd.cur_home    = 1'b0;
    cmd.cur_newline = 1'b0;
    cmd.cur_step    = 1'b0;
    cmd.mark_scroll = 1'b0;
    cmd.emit        = EMIT_OFF;
    cmd.emit_last   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.mem_op     = MEM_BLANK;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch_item = 1'b1;
          state_next     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.func)
          FUNC_CLEAR: begin
            cmd.sweep_zero = 1'b1;
            state_next     = ST_CLEAR;
          end
          FUNC_READ: begin
            cmd.mem_op = MEM_READ;
            state_next = ST_READ;
          end
          FUNC_PUT: begin
            if (sts.is_newline || sts.wrap_pending) begin
              if (sts.last_row) begin
                cmd.sweep_zero = 1'b1;
                state_next     = ST_COPY;
              end else begin
                cmd.cur_newline = 1'b1;
                state_next      = ST_FINISH;
              end
            end else begin
              state_next = ST_PUT;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.mem_op     = MEM_BLANK;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_end) begin
          cmd.cur_home = 1'b1;
          state_next   = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.emit      = EMIT_READ;
        cmd.emit_last = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_COPY: begin
        cmd.mem_op     = MEM_COPY;
        cmd.sweep_step = 1'b1;
        if (sts.copy_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.mem_op     = MEM_FILL;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_end) begin
          cmd.cur_newline = 1'b1;
          cmd.mark_scroll = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.func == FUNC_PUT && !sts.is_newline) begin
          state_next = ST_PUT;
        end else begin
          cmd.emit      = EMIT_BARE;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_PUT: begin
        cmd.mem_op    = MEM_PUT;
        cmd.cur_step  = 1'b1;
        cmd.emit      = EMIT_PUT;
        cmd.emit_last = sts.put_last;
        if (sts.put_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tcw_datapath.sv =====
// Screen store, cursor, sweep counter and result register of the console writer.
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_pkg::tcw_item_t   item,
  input  logic [7:0]           text_attribute,
  input  tcw_pkg::tcw_cmd_t    cmd,
  output tcw_pkg::tcw_status_t sts,
  output tcw_pkg::tcw_result_t result,
  output logic                 result_valid
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  logic [15:0]   mem [CELLS];

  logic [1:0]    func_q;
  logic [7:0]    char_q;
  logic [10:0]   raddr_q;
  logic          scrolled;
  logic [RW-1:0] cur_row, row_next;
  logic [CW-1:0] cur_col, col_next, col_inc;
  logic [AW-1:0] sweep;
  logic          copy_vld;
  logic [AW-1:0] copy_waddr;
  logic [15:0]   rd_data;
  logic [AW-1:0] cur_addr;
  logic [15:0]   put_val, rd_val;
  logic          is_tab, last_row;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      func_q  <= item.func;
      char_q  <= item.char_code;
      raddr_q <= item.read_addr;
    end
  end

  assign is_tab   = (char_q == CH_TAB);
  assign last_row = (cur_row == RW'(ROWS - 1));
  assign col_inc  = cur_col + CW'(1);
  assign cur_addr = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign put_val  = {text_attribute, (is_tab ? CH_SPACE : char_q)};
  assign rd_val   = (32'(raddr_q) < CELLS) ? rd_data : 16'h0000;

  // Cursor
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    if (cmd.cur_home) begin
      row_next = '0;
      col_next = '0;
    end
    if (cmd.cur_newline) begin
      if (!last_row) begin
        row_next = cur_row + RW'(1);
      end
      col_next = '0;
    end
    if (cmd.cur_step) begin
      col_next = col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      sweep    <= '0;
      copy_vld <= 1'b0;
      scrolled <= 1'b0;
    end else begin
      cur_row  <= row_next;
      cur_col  <= col_next;
      copy_vld <= (cmd.mem_op == MEM_COPY);
      if (cmd.sweep_zero) begin
        sweep <= '0;
      end else if (cmd.sweep_step) begin
        sweep <= sweep + AW'(1);
      end
      if (cmd.latch_item) begin
        scrolled <= 1'b0;
      end else if (cmd.mark_scroll) begin
        scrolled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr <= sweep;
  end

  // Store ports: the copy write, registered behind its read, wins the write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = BLANK_CELL;
    rd_en   = 1'b0;
    rd_addr = sweep + COLS_A;
    if (copy_vld) begin
      wr_en   = 1'b1;
      wr_addr = copy_waddr;
      wr_data = rd_data;
    end else begin
      case (cmd.mem_op)
        MEM_BLANK: begin
          wr_en = 1'b1;
        end
        MEM_FILL: begin
          wr_en   = 1'b1;
          wr_data = {text_attribute, CH_SPACE};
        end
        MEM_PUT: begin
          wr_en   = 1'b1;
          wr_addr = cur_addr;
          wr_data = put_val;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    case (cmd.mem_op)
      MEM_COPY: rd_en = 1'b1;
      MEM_READ: begin
        rd_en   = 1'b1;
        rd_addr = AW'(raddr_q);
      end
      default:  rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Status
  always_comb begin
    sts.func         = func_q;
    sts.is_newline   = (char_q == CH_NEWLINE);
    sts.wrap_pending = (cur_col == CW'(COLS));
    sts.last_row     = last_row;
    sts.copy_end     = (sweep == AW'(CELLS - COLS - 1));
    sts.sweep_end    = (sweep == AW'(CELLS - 1));
    sts.put_last     = !is_tab || (col_inc[1:0] == TAB_ALIGNED) || (col_inc == CW'(COLS));
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != EMIT_OFF);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_OFF) begin
      result.cell_written <= (cmd.emit == EMIT_PUT);
      result.scrolled     <= scrolled;
      result.cursor_row   <= 5'(row_next);
      result.cursor_col   <= 7'(col_next);
      result.last         <= cmd.emit_last;
      case (cmd.emit)
        EMIT_PUT: begin
          result.cell_addr  <= 11'(cur_addr);
          result.cell_value <= put_val;
        end
        EMIT_READ: begin
          result.cell_addr  <= raddr_q;
          result.cell_value <= rd_val;
        end
        default: begin
          result.cell_addr  <= '0;
          result.cell_value <= '0;
        end
      endcase
    end
  end

endmodule

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: APB register, controller and datapath.
`timescale 1ns / 1ps

// Text-mode console engine. A word is taken when start is high and busy is
// low; each result word shows on result for one cycle with result_valid high,
// and the receiver cannot stall it, so it must take every strobe. A plain
// character, a newline without scroll, a read, and the no-op code each pass
// from idle through dispatch and one finishing state back to idle; a tab
// writes one space per cycle (up to 4). A clear walks every cell once through
// the single store write port. A newline or wrap on the last row scrolls:
// each cell is copied one row up, one per cycle through the read and write
// ports, then the last row is blanked. After reset a clearing pass fills the
// store's ROWS*COLS cells (2000 at the default size) with blank cells; busy
// stays high during it, while the APB register still takes writes.
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                start,
  output logic                busy,
  input  tcw_pkg::tcw_item_t  item,
  // result channel
  output logic                result_valid,
  output tcw_pkg::tcw_result_t result,
  // APB register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcw_pkg::*;

  logic        [7:0] text_attribute;
  tcw_cmd_t          cmd;
  tcw_status_t       sts;
  logic              reg_wr;

  // Single register at byte 0; paddr[2] selects the register word
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (reg_wr && paddr[2] == REG_TEXT_ATTR) begin
      text_attribute <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'h000000, text_attribute} : 32'h0;

  // Controller decides the sequence; datapath owns store and cursor
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .text_attribute (text_attribute),
    .cmd            (cmd),
    .sts            (sts),
    .result         (result),
    .result_valid   (result_valid)
  );

`ifndef SYNTHESIS
  // An accepted word always raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepting a word");

  // The final result of a word is never followed directly by another result
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result right after final result");

  // Intermediate results only come while the word is still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result while idle");
`endif

endmodule

// ===== tb/tcw_result_checker.sv =====
// Result checker for the text console writer: screen and cursor shadow, result word compare.
`timescale 1ns / 1ps

module tcw_result_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  tcw_pkg::tcw_item_t   item,
  input  logic                 result_valid,
  input  tcw_pkg::tcw_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output int                   error_count,
  output int                   words_pending
);
  import tcw_pkg::*;

  localparam int CELLS     = ROWS * COLS;
  localparam int SW        = $clog2(CELLS);
  localparam int TAB_WIDTH = 4;

  logic [15:0]   screen [CELLS];
  int unsigned   cur_row;
  int unsigned   cur_col;
  logic [7:0]    text_attr;
  tcw_result_t   cell_reports [$];

  function automatic string word_text(input tcw_result_t r);
    return $sformatf("addr=%0d value=%h written=%b scrolled=%b row=%0d col=%0d last=%b",
                     r.cell_addr, r.cell_value, r.cell_written, r.scrolled,
                     r.cursor_row, r.cursor_col, r.last);
  endfunction

  // Queue one expected word; the cursor fields are taken as they stand now.
  function automatic void report(input int unsigned addr, input logic [15:0] value,
                                 input logic wr, input logic sc, input logic last);
    tcw_result_t r;
    r.cell_addr    = addr[10:0];
    r.cell_value   = value;
    r.cell_written = wr;
    r.scrolled     = sc;
    r.cursor_row   = cur_row[4:0];
    r.cursor_col   = cur_col[6:0];
    r.last         = last;
    cell_reports.push_back(r);
  endfunction

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen[SW'(i)] = BLANK_CELL;
    cur_row = 0;
    cur_col = 0;
  endfunction

  // Move to a new line; on the bottom row the screen scrolls up instead.
  function automatic logic next_line();
    int i;
    logic sc;
    sc = 1'b0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
    end else begin
      for (i = 0; i < CELLS - COLS; i++) screen[SW'(i)] = screen[SW'(i + COLS)];
      for (i = CELLS - COLS; i < CELLS; i++) screen[SW'(i)] = {text_attr, CH_SPACE};
      sc = 1'b1;
    end
    cur_col = 0;
    return sc;
  endfunction

  function automatic void predict_console_op(input tcw_item_t w);
    logic        sc;
    int unsigned addr;
    int unsigned spaces;
    int unsigned k;
    logic [15:0] glyph;
    sc    = 1'b0;
    glyph = {text_attr, w.char_code};
    case (w.func)
      FUNC_PUT: begin
        if (w.char_code == CH_NEWLINE) begin
          sc = next_line();
          report(0, 16'h0000, 1'b0, sc, 1'b1);
        end else if (w.char_code == CH_TAB) begin
          if (cur_col >= COLS) sc = next_line();
          // pad to the next tab stop, but never past the pending-wrap column
          spaces = TAB_WIDTH - cur_col % TAB_WIDTH;
          if (spaces > COLS - cur_col) spaces = COLS - cur_col;
          for (k = 0; k < spaces; k++) begin
            addr = cur_row * COLS + cur_col;
            screen[SW'(addr)] = {text_attr, CH_SPACE};
            cur_col++;
            report(addr, {text_attr, CH_SPACE}, 1'b1, sc, k + 1 == spaces);
          end
        end else begin
          if (cur_col >= COLS) sc = next_line();
          addr = cur_row * COLS + cur_col;
          if (addr < CELLS) screen[SW'(addr)] = glyph;
          cur_col++;
          report(addr, glyph, 1'b1, sc, 1'b1);
        end
      end
      FUNC_CLEAR: begin
        blank_screen();
        report(0, 16'h0000, 1'b0, 1'b0, 1'b1);
      end
      FUNC_READ: begin
        report(32'(w.read_addr), (w.read_addr < CELLS) ? screen[w.read_addr] : 16'h0000,
               1'b0, 1'b0, 1'b1);
      end
      default: report(0, 16'h0000, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    tcw_result_t want;
    if (rst) begin
      blank_screen();
      text_attr = ATTR_RESET;
      cell_reports.delete();
      error_count = 0;
    end else begin
      if (result_valid === 1'b1) begin
        if (cell_reports.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected: %s", $time, word_text(result));
        end else begin
          want = cell_reports.pop_front();
          if (result !== want) begin
            error_count++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $time, word_text(want), word_text(result));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) predict_console_op(item);
      if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR)
        text_attr = pwdata[7:0];
    end
    words_pending = cell_reports.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the text console writer: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;
  // Func code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Random words per attribute phase (four phases).
  localparam int PHASE_WORDS = 50;
  // A scroll or clear walks all ROWS*COLS cells; the init pass does too.
  // Even if every one of the roughly 240 words scrolled or cleared, with the
  // longest gaps, this limit leaves several times the run time they would need.
  localparam int CYCLE_LIMIT  = 2000000;
  // Longest single operation, waited out after the last expected word.
  localparam int DRAIN_CYCLES = CELLS + 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  tcw_item_t   item;
  logic        result_valid;
  tcw_result_t result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int words_pending;
  int cycle_count = 0;
  int burst_left  = 0;   // words still to send back to back
  int words_sent  = 0;

  always #2 clk = ~clk;

  text_console_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tcw_result_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .error_count  (error_count),
    .words_pending(words_pending)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one command word and hold it until the block takes it (start high,
  // busy low at the edge). Start stays high into the next word while a burst
  // lasts; at the end of a burst it drops for a random gap. The gap is the
  // only NBA to start in its step, so start never glitches low-high.
  task automatic send_word(input logic [1:0] fn, input logic [7:0] ch,
                           input logic [10:0] addr);
    start <= 1'b1;
    item  <= {fn, ch, addr};
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // mostly short bursts, now and then a long gapless stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Printable byte: anything but tab and newline, zero and 8'hFF included.
  function automatic logic [7:0] any_glyph();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_TAB || c == CH_NEWLINE);
    return c;
  endfunction

  // Read a cell where short lines land, so store contents get checked.
  task automatic read_near();
    send_word(FUNC_READ, 8'($urandom_range(0, 255)),
              11'($urandom_range(0, ROWS - 1) * COLS + $urandom_range(0, 11)));
  endtask

  // One text line: glyphs, tabs and now and then a read until about 'width' columns, then newline.
  // Widths past COLS run through the pending wrap into the next row.
  // Unused fields carry random junk.
  task automatic type_line(input int unsigned width, input int unsigned tab_pct);
    int unsigned col;
    col = 0;
    while (col < width) begin
      if ($urandom_range(0, 99) < tab_pct) begin
        send_word(FUNC_PUT, CH_TAB, 11'($urandom_range(0, 2047)));
        col = (col / 4 + 1) * 4;
      end else if ($urandom_range(0, 99) < 8) begin
        read_near();
      end else begin
        send_word(FUNC_PUT, any_glyph(), 11'($urandom_range(0, 2047)));
        col++;
      end
    end
    send_word(FUNC_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
  endtask

  // Wait for the block to go quiet: nothing owed, busy low. Sampled on the
  // falling edge so the checker's rising-edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk); while (words_pending != 0 || busy !== 1'b0);
  endtask

  // APB write of text_attribute: setup cycle, then access until pready.
  task automatic write_attr(input logic [7:0] value);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TEXT_ATTR, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned pick;
    int          phase_start;
    logic [7:0]  attr_value;

    rst     <= 1'b1;
    start   <= 1'b0;
    item    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset attribute. send_word waits out the init pass.
    send_word(FUNC_READ, 8'h00, 11'd0);           // blank cell after reset
    send_word(FUNC_READ, 8'hFF, 11'(CELLS - 1));  // last cell
    send_word(FUNC_READ, 8'h00, 11'(CELLS));      // first address out of range
    send_word(FUNC_READ, 8'h00, 11'h7FF);         // all address bits set
    send_word(FUNC_PUT, 8'h48, 11'h7FF);
    send_word(FUNC_PUT, 8'h00, 11'd0);            // NUL is written as is
    send_word(FUNC_PUT, 8'hFF, 11'd0);
    send_word(FUNC_PUT, CH_TAB, 11'd0);           // col 3 -> 4, one space
    send_word(FUNC_PUT, 8'h78, 11'd0);
    send_word(FUNC_PUT, CH_TAB, 11'd0);           // col 5 -> 8, three spaces
    send_word(FUNC_PUT, CH_NEWLINE, 11'd0);
    send_word(FUNC_PUT, CH_TAB, 11'd0);           // col 0 -> 4, full four
    send_word(FUNC_READ, 8'h00, 11'd0);
    send_word(FUNC_READ, 8'h00, 11'd1);
    send_word(FUNC_READ, 8'h00, 11'(COLS));
    send_word(FUNC_UNUSED, 8'hA5, 11'h555);       // no-op code
    send_word(FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_word(FUNC_READ, 8'h00, 11'd0);           // blank again
    send_word(FUNC_READ, 8'h00, 11'(COLS + 1));

    // Random phases, each under its own attribute: both extremes first.
    for (phase = 0; phase < 4; phase++) begin
      start <= 1'b0;
      case (phase)
        0:       attr_value = 8'h00;
        1:       attr_value = 8'hFF;
        default: attr_value = 8'($urandom_range(1, 254));
      endcase
      write_attr(attr_value);
      phase_start = words_sent;
      // One long line first: drives the pending wrap and wrap-then-tab/glyph.
      type_line($urandom_range(78, 86), 70);
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
          send_word(FUNC_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end else if (pick < 4) begin
          send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end else if (pick < 11) begin
          send_word(FUNC_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end else if (pick < 19) begin
          read_near();
        end else if (pick < 30) begin
          // runs of empty lines push the cursor to the bottom row and scroll
          repeat ($urandom_range(2, 6))
            send_word(FUNC_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
        end else begin
          type_line($urandom_range(0, 5), 15);
        end
      end
    end

    // Drain: everything owed must arrive, then nothing more may show up.
    start <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
